@@ sv/char_lcd_4bit_writer_unit_macros.svh @@
// assertion macros for the character lcd writer
// no dependencies; included by files that carry concurrent checks
`ifndef CHAR_LCD_4BIT_WRITER_UNIT_MACROS_SVH
`define CHAR_LCD_4BIT_WRITER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define LCDW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define LCDW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define LCDW_ASSERT(lbl, clk, rstn, prop, msg)
`define LCDW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ sv/lcdw_pkg.sv @@
// shared types, codes and sequencing functions for the character lcd writer
// no dependencies; imported by front, back and top level
package lcdw_pkg;

    // action codes on the input stream
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_CMD    = 3'd1;
    localparam logic [2:0] ACT_DATA   = 3'd2;
    localparam logic [2:0] ACT_INIT   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;
    localparam logic [2:0] ACT_CURSOR = 3'd5;

    // classified operations handed from front to back
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_NOP   = 3'd1;
    localparam logic [2:0] OP_BYTE  = 3'd2;
    localparam logic [2:0] OP_INIT  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // pulse phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_EN_LOW  = 3'd1;
    localparam logic [2:0] PH_EN_HIGH = 3'd2;
    localparam logic [2:0] PH_HOLD    = 3'd3;
    localparam logic [2:0] PH_GAP     = 3'd4;
    localparam logic [2:0] PH_WAIT    = 3'd5;

    // init step kinds
    localparam logic [1:0] STEP_WAIT   = 2'd0;
    localparam logic [1:0] STEP_NIBBLE = 2'd1;
    localparam logic [1:0] STEP_CMD    = 2'd2;

    localparam logic [4:0]  INIT_FIRST    = 5'd1;
    localparam logic [4:0]  INIT_LAST     = 5'd18;
    localparam logic [15:0] CLEAR_WAIT_US = 16'd2000;

    // command bytes and address offset
    localparam logic [7:0] CLEAR_CMD   = 8'h01;
    localparam logic [7:0] CURSOR_CMD  = 8'h80;
    localparam logic [6:0] ROW1_OFFSET = 7'h40;

    // configuration register indexes
    localparam logic [1:0] CFG_PULSE = 2'd0;
    localparam logic [1:0] CFG_HOLD  = 2'd1;
    localparam logic [1:0] CFG_GAP   = 2'd2;

    localparam logic [7:0] PULSE_RESET = 8'd2;
    localparam logic [9:0] HOLD_RESET  = 10'd150;
    localparam logic [9:0] GAP_RESET   = 10'd20;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] byte_value;
        logic       rs;
    } item_t;

    // result word, rs_pin in the lowest bit
    typedef struct packed {
        logic       accepted;
        logic       busy_res;
        logic [3:0] data_pins;
        logic       en_pin;
        logic       rs_pin;
    } res_t;

    typedef struct packed {
        logic [7:0] pulse;
        logic [9:0] hold;
        logic [9:0] gap;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] cnt;
        logic [7:0]  pbyte;
        logic        nib;
        logic [4:0]  step;
        logic        rs;
        logic        en;
        logic [3:0]  data;
        logic        clr;
    } st_t;

    // back-end status seen by the top level checks
    typedef struct packed {
        logic settling;
        logic idle;
    } stat_t;

    // init sequence table
    function automatic logic [1:0] step_kind(input logic [4:0] s);
        logic [1:0] k;
        unique case (s)
            5'd2, 5'd4, 5'd6, 5'd8:                        k = STEP_NIBBLE;
            5'd10, 5'd11, 5'd12, 5'd13, 5'd15, 5'd17, 5'd18: k = STEP_CMD;
            default:                                       k = STEP_WAIT;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] step_value(input logic [4:0] s);
        logic [15:0] v;
        unique case (s)
            5'd1:                v = 16'd50000;
            5'd3, 5'd5, 5'd7:    v = 16'd5000;
            5'd9, 5'd14, 5'd16:  v = 16'd2000;
            5'd2, 5'd4, 5'd6:    v = 16'h03;
            5'd8:                v = 16'h02;
            5'd10:               v = 16'h08;
            5'd11:               v = 16'h28;
            5'd12:               v = 16'h0C;
            5'd13:               v = 16'h02;
            5'd15:               v = 16'h01;
            5'd17:               v = 16'h06;
            5'd18:               v = 16'h0C;
            default:             v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic st_t begin_nibble(input st_t s, input logic [3:0] n, input cfg_t c);
        st_t r;
        r = s;
        r.data  = n;
        r.en    = 1'b0;
        r.phase = PH_EN_LOW;
        r.cnt   = {8'd0, c.pulse};
        return r;
    endfunction

    function automatic st_t begin_byte(input st_t s, input logic [7:0] b, input logic rs,
                                       input cfg_t c);
        st_t r;
        r = s;
        r.pbyte = b;
        r.nib   = 1'b0;
        r.rs    = rs;
        return begin_nibble(r, b[7:4], c);
    endfunction

    function automatic st_t begin_init_step(input st_t s, input cfg_t c);
        st_t r;
        logic [15:0] v;
        r = s;
        v = step_value(s.step);
        if (s.step == 5'd0 || s.step > INIT_LAST) begin
            r.step  = 5'd0;
            r.phase = PH_IDLE;
            r.cnt   = 16'd0;
        end else if (step_kind(s.step) == STEP_WAIT) begin
            r.phase = PH_WAIT;
            r.cnt   = v;
        end else if (step_kind(s.step) == STEP_NIBBLE) begin
            // lone nibble of the 8-bit to 4-bit handover
            r.pbyte = v[7:0];
            r.nib   = 1'b1;
            r.rs    = 1'b0;
            r = begin_nibble(r, v[3:0], c);
        end else begin
            r = begin_byte(r, v[7:0], 1'b0, c);
        end
        return r;
    endfunction

    function automatic st_t finish_item(input st_t s, input cfg_t c);
        st_t r;
        r = s;
        if (s.clr) begin
            r.clr   = 1'b0;
            r.phase = PH_WAIT;
            r.cnt   = CLEAR_WAIT_US;
        end else if (s.step != 5'd0) begin
            r.step = s.step + 5'd1;
            r = begin_init_step(r, c);
        end else begin
            r.phase = PH_IDLE;
            r.cnt   = 16'd0;
        end
        return r;
    endfunction

    function automatic logic raw_nibble(input st_t s);
        return s.step != 5'd0 && s.step <= INIT_LAST && step_kind(s.step) == STEP_NIBBLE;
    endfunction

    // one phase transition once the current wait has run out
    function automatic st_t advance(input st_t s, input cfg_t c);
        st_t r;
        r = s;
        unique case (s.phase)
            PH_EN_LOW: begin
                r.en    = 1'b1;
                r.phase = PH_EN_HIGH;
                r.cnt   = {8'd0, c.pulse};
            end
            PH_EN_HIGH: begin
                r.en    = 1'b0;
                r.phase = PH_HOLD;
                r.cnt   = {6'd0, c.hold};
            end
            PH_HOLD: begin
                if (!s.nib) begin
                    r.nib = 1'b1;
                    r = begin_nibble(r, s.pbyte[3:0], c);
                end else if (!s.rs && !raw_nibble(s)) begin
                    r.phase = PH_GAP;
                    r.cnt   = {6'd0, c.gap};
                end else begin
                    r = finish_item(r, c);
                end
            end
            PH_GAP, PH_WAIT: begin
                r = finish_item(r, c);
            end
            default: begin
                r.phase = PH_IDLE;
                r.cnt   = 16'd0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/lcdw_fifo.sv @@
// small register queue with valid/ready on both sides
// no dependencies; used between front and back and at the result side
module lcdw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ sv/lcdw_front.sv @@
// front end: takes input transactions, turns actions into operations
// depends on lcdw_pkg and lcdw_fifo
module lcdw_front #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_action,
    input  logic [7:0]          in_byte_value,
    input  logic                in_row,
    input  logic [5:0]          in_column,
    output logic                q_valid,
    input  logic                q_ready,
    output lcdw_pkg::item_t     q_item
);
    import lcdw_pkg::*;

    item_t                 cls;
    logic [6:0]            addr;
    logic [$bits(item_t)-1:0] q_raw;

    // cursor address wraps at 128
    assign addr = (in_row ? ROW1_OFFSET : 7'h00) + {1'b0, in_column};

    // classify the action
    always_comb begin
        cls.op         = OP_NOP;
        cls.byte_value = in_byte_value;
        cls.rs         = 1'b0;
        unique case (in_action)
            ACT_TICK:   cls.op = OP_TICK;
            ACT_CMD:    cls.op = OP_BYTE;
            ACT_DATA: begin
                cls.op = OP_BYTE;
                cls.rs = 1'b1;
            end
            ACT_INIT:   cls.op = OP_INIT;
            ACT_CLEAR: begin
                cls.op         = OP_CLEAR;
                cls.byte_value = CLEAR_CMD;
            end
            ACT_CURSOR: begin
                cls.op         = OP_BYTE;
                cls.byte_value = CURSOR_CMD | {1'b0, addr};
            end
            default:    cls.op = OP_NOP;
        endcase
    end

    // queue toward the back end
    lcdw_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (cls),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_raw)
    );

    assign q_item = item_t'(q_raw);

endmodule

@@ sv/lcdw_back.sv @@
// back end: pin sequencer, wait counter, config registers, result queue
// depends on lcdw_pkg and lcdw_fifo
module lcdw_back #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  lcdw_pkg::item_t     q_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [9:0]          cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lcdw_pkg::res_t      m_res,
    output lcdw_pkg::stat_t     stat
);
    import lcdw_pkg::*;

    st_t   st_reg, st_next;
    cfg_t  cfg_reg;
    logic  settling_reg, settling_next;
    logic  acc_reg, acc_next;
    st_t   adv_st, app_st;
    logic  app_acc;
    logic  space;
    logic  push;
    res_t  res;
    logic [$bits(res_t)-1:0] m_raw;

    // effect of one item on the sequencer, before settling
    function automatic st_t apply(input st_t s, input item_t it, input cfg_t c);
        st_t  r;
        logic idle;
        r = s;
        idle = s.phase == PH_IDLE;
        unique case (it.op)
            OP_TICK: begin
                if (!idle && s.cnt != 16'd0) begin
                    r.cnt = s.cnt - 16'd1;
                end
            end
            OP_BYTE: begin
                if (idle) begin
                    r = begin_byte(r, it.byte_value, it.rs, c);
                end
            end
            OP_INIT: begin
                if (idle) begin
                    r.rs   = 1'b0;
                    r.en   = 1'b0;
                    r.data = 4'd0;
                    r.clr  = 1'b0;
                    r.step = INIT_FIRST;
                    r = begin_init_step(r, c);
                end
            end
            OP_CLEAR: begin
                if (idle) begin
                    r.clr = 1'b1;
                    r = begin_byte(r, it.byte_value, 1'b0, c);
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    assign adv_st  = advance(st_reg, cfg_reg);
    assign app_st  = apply(st_reg, q_item, cfg_reg);
    assign app_acc = (st_reg.phase == PH_IDLE) &&
                     (q_item.op == OP_BYTE || q_item.op == OP_INIT || q_item.op == OP_CLEAR);

    assign q_ready   = !settling_reg && space;
    assign cfg_ready = 1'b1;

    // one transition per cycle, stalled when the result queue is full
    always_comb begin
        st_next       = st_reg;
        settling_next = settling_reg;
        acc_next      = acc_reg;
        push          = 1'b0;
        if (settling_reg) begin
            if (space) begin
                st_next = adv_st;
                if (adv_st.phase == PH_IDLE || adv_st.cnt != 16'd0) begin
                    settling_next = 1'b0;
                    push          = 1'b1;
                end
            end
        end else if (q_valid && space) begin
            st_next = app_st;
            if (app_st.phase != PH_IDLE && app_st.cnt == 16'd0) begin
                settling_next = 1'b1;
                acc_next      = app_acc;
            end else begin
                push = 1'b1;
            end
        end
    end

    // result word from the settled state
    always_comb begin
        res.rs_pin    = st_next.rs;
        res.en_pin    = st_next.en;
        res.data_pins = st_next.data;
        res.busy_res  = st_next.phase != PH_IDLE;
        res.accepted  = settling_reg ? acc_reg : app_acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= '0;
            settling_reg <= 1'b0;
            acc_reg      <= 1'b0;
        end else begin
            st_reg       <= st_next;
            settling_reg <= settling_next;
            acc_reg      <= acc_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse <= PULSE_RESET;
            cfg_reg.hold  <= HOLD_RESET;
            cfg_reg.gap   <= GAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PULSE: cfg_reg.pulse <= cfg_data[7:0];
                CFG_HOLD:  cfg_reg.hold  <= cfg_data;
                CFG_GAP:   cfg_reg.gap   <= cfg_data;
                default:   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    // result queue
    lcdw_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (DEPTH)
    ) u_results (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (space),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_raw)
    );

    assign m_res = res_t'(m_raw);

    assign stat.settling = settling_reg;
    assign stat.idle     = st_reg.phase == PH_IDLE;

endmodule

@@ sv/char_lcd_4bit_writer_unit.sv @@
// top level of the 4-bit character lcd writer
// depends on lcdw_pkg, lcdw_front, lcdw_back and the assertion macro header
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-----------------------------------
//  s_*       | in        | s_tvalid/s_tready  | tdata byte,row,column; tuser action
//  m_*       | out       | m_tvalid/m_tready  | tdata rs,en,data,busy,accepted
//  cfg_*     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one transaction per cycle when every wait it touches is nonzero and the result
// queue has room; each phase that runs out within the same item costs another
// transition of the back-end sequencer, which then holds the queue.
// reset is synchronous, active low, clears queues and sequencer state and reloads the config registers.
// either side may stall; the queues keep front and back running independently.
`include "char_lcd_4bit_writer_unit_macros.svh"

module char_lcd_4bit_writer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] byte_value, [8] row, [14:9] column, [15] zero
    input  logic [15:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] rs_pin, [1] en_pin, [5:2] data_pins, [6] busy_res, [7] accepted
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import lcdw_pkg::*;

    logic  q_valid, q_ready;
    item_t q_item;
    res_t  m_res;
    stat_t stat;

    lcdw_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_action     (s_tuser),
        .in_byte_value (s_tdata[7:0]),
        .in_row        (s_tdata[8]),
        .in_column     (s_tdata[14:9]),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    lcdw_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res),
        .stat      (stat)
    );

    assign m_tdata = m_res;

    // checks
    `LCDW_ASSERT(a_idle_en_low, aclk, aresetn, !(m_tvalid && !m_res.busy_res && m_res.en_pin), "enable high while idle")
    `LCDW_ASSERT(a_settle_holds_queue, aclk, aresetn, !(stat.settling && q_ready), "item taken while settling")
    `LCDW_ASSERT(a_settle_active, aclk, aresetn, !(stat.settling && stat.idle), "settling with no active phase")
    `LCDW_ASSERT_NEXT(a_nop_result, aclk, aresetn, q_valid && q_ready && q_item.op == OP_NOP, m_tvalid, "no result after ignored action")

endmodule

@@ tb/char_lcd_4bit_writer_unit_test.sv @@
// self-checking testbench for the 4-bit character lcd writer
// depends on lcdw_pkg and char_lcd_4bit_writer_unit; predicts pin levels per transaction
// and compares every result word against that prediction
module char_lcd_4bit_writer_unit_test;
    import lcdw_pkg::*;

    // no register answers to this index, writes to it must change nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // waits longer than this are ticked through back to back
    localparam int LONG_WAIT_US = 40;

    // predicted lcd pin levels and the queue of results still to arrive
    class pin_level_checker;
        logic [7:0]  pulse_us;
        logic [9:0]  hold_us;
        logic [9:0]  gap_us;
        logic [2:0]  phase;
        logic [15:0] countdown;
        logic [7:0]  held_byte;
        logic        low_half;
        logic [4:0]  init_idx;
        logic        rs;
        logic        en;
        logic [3:0]  dq;
        logic        clear_wait_due;
        logic [1:0]  seq_kind [32];
        logic [15:0] seq_arg [32];
        res_t        pending_pin_levels[$];
        int          mismatch_count;

        function new();
            foreach (seq_kind[i]) begin
                seq_kind[i] = STEP_WAIT;
                seq_arg[i]  = 16'd0;
            end
            // power-on sequence: long waits, lone nibbles, then full commands
            add_step(1, STEP_WAIT, 16'd50000);
            add_step(2, STEP_NIBBLE, 16'h03);
            add_step(3, STEP_WAIT, 16'd5000);
            add_step(4, STEP_NIBBLE, 16'h03);
            add_step(5, STEP_WAIT, 16'd5000);
            add_step(6, STEP_NIBBLE, 16'h03);
            add_step(7, STEP_WAIT, 16'd5000);
            add_step(8, STEP_NIBBLE, 16'h02);
            add_step(9, STEP_WAIT, 16'd2000);
            add_step(10, STEP_CMD, 16'h08);
            add_step(11, STEP_CMD, 16'h28);
            add_step(12, STEP_CMD, 16'h0C);
            add_step(13, STEP_CMD, 16'h02);
            add_step(14, STEP_WAIT, 16'd2000);
            add_step(15, STEP_CMD, {8'd0, CLEAR_CMD});
            add_step(16, STEP_WAIT, 16'd2000);
            add_step(17, STEP_CMD, 16'h06);
            add_step(18, STEP_CMD, 16'h0C);
            pulse_us       = PULSE_RESET;
            hold_us        = HOLD_RESET;
            gap_us         = GAP_RESET;
            phase          = PH_IDLE;
            countdown      = 16'd0;
            held_byte      = 8'd0;
            low_half       = 1'b0;
            init_idx       = 5'd0;
            rs             = 1'b0;
            en             = 1'b0;
            dq             = 4'd0;
            clear_wait_due = 1'b0;
            mismatch_count = 0;
        endfunction

        function void add_step(int idx, logic [1:0] kind, logic [15:0] arg);
            seq_kind[idx] = kind;
            seq_arg[idx]  = arg;
        endfunction

        function void set_register(logic [1:0] idx, logic [9:0] value);
            case (idx)
                CFG_PULSE: pulse_us = value[7:0];
                CFG_HOLD:  hold_us  = value;
                CFG_GAP:   gap_us   = value;
                default: ;
            endcase
        endfunction

        function void start_phase(logic [2:0] ph, logic [15:0] us);
            phase     = ph;
            countdown = us;
        endfunction

        function void start_nibble(logic [3:0] nib);
            dq = nib;
            en = 1'b0;
            start_phase(PH_EN_LOW, {8'd0, pulse_us});
        endfunction

        function void start_byte(logic [7:0] b, logic sel);
            held_byte = b;
            low_half  = 1'b0;
            rs        = sel;
            start_nibble(b[7:4]);
        endfunction

        function void start_init_step();
            if (init_idx == 5'd0 || init_idx > INIT_LAST) begin
                init_idx = 5'd0;
                start_phase(PH_IDLE, 16'd0);
            end else if (seq_kind[init_idx] == STEP_WAIT) begin
                start_phase(PH_WAIT, seq_arg[init_idx]);
            end else if (seq_kind[init_idx] == STEP_NIBBLE) begin
                // single nibble, no high half and no command gap
                held_byte = seq_arg[init_idx][7:0];
                low_half  = 1'b1;
                rs        = 1'b0;
                start_nibble(seq_arg[init_idx][3:0]);
            end else begin
                start_byte(seq_arg[init_idx][7:0], 1'b0);
            end
        endfunction

        function void end_of_item();
            if (clear_wait_due) begin
                clear_wait_due = 1'b0;
                start_phase(PH_WAIT, CLEAR_WAIT_US);
            end else if (init_idx != 5'd0) begin
                init_idx = init_idx + 5'd1;
                start_init_step();
            end else begin
                start_phase(PH_IDLE, 16'd0);
            end
        endfunction

        function void next_phase();
            case (phase)
                PH_EN_LOW: begin
                    en = 1'b1;
                    start_phase(PH_EN_HIGH, {8'd0, pulse_us});
                end
                PH_EN_HIGH: begin
                    en = 1'b0;
                    start_phase(PH_HOLD, {6'd0, hold_us});
                end
                PH_HOLD: begin
                    if (!low_half) begin
                        low_half = 1'b1;
                        start_nibble(held_byte[3:0]);
                    end else if (!rs && !(init_idx != 5'd0 && init_idx <= INIT_LAST
                                          && seq_kind[init_idx] == STEP_NIBBLE)) begin
                        start_phase(PH_GAP, {6'd0, gap_us});
                    end else begin
                        end_of_item();
                    end
                end
                PH_GAP, PH_WAIT: end_of_item();
                default: start_phase(PH_IDLE, 16'd0);
            endcase
        endfunction

        // predict the pin levels after one accepted input transaction
        function void note_input(logic [2:0] act, logic [7:0] b, logic row, logic [5:0] col);
            res_t       want;
            logic       took;
            logic [6:0] addr;
            took = 1'b0;
            if (act == ACT_TICK) begin
                if (phase != PH_IDLE) begin
                    if (countdown != 16'd0)
                        countdown = countdown - 16'd1;
                    while (phase != PH_IDLE && countdown == 16'd0)
                        next_phase();
                end
            end else if (act <= ACT_CURSOR && phase == PH_IDLE) begin
                took = 1'b1;
                case (act)
                    ACT_CMD:  start_byte(b, 1'b0);
                    ACT_DATA: start_byte(b, 1'b1);
                    ACT_INIT: begin
                        rs             = 1'b0;
                        en             = 1'b0;
                        dq             = 4'd0;
                        clear_wait_due = 1'b0;
                        init_idx       = INIT_FIRST;
                        start_init_step();
                    end
                    ACT_CLEAR: begin
                        clear_wait_due = 1'b1;
                        start_byte(CLEAR_CMD, 1'b0);
                    end
                    ACT_CURSOR: begin
                        // ddram address wraps at 128
                        addr = (row ? ROW1_OFFSET : 7'd0) + {1'b0, col};
                        start_byte(CURSOR_CMD | {1'b0, addr}, 1'b0);
                    end
                    default: ;
                endcase
                while (phase != PH_IDLE && countdown == 16'd0)
                    next_phase();
            end
            want.rs_pin    = rs;
            want.en_pin    = en;
            want.data_pins = dq;
            want.busy_res  = (phase != PH_IDLE);
            want.accepted  = took;
            pending_pin_levels.push_back(want);
        endfunction

        function void report(string what, logic [3:0] want, logic [3:0] got);
            if (mismatch_count < 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
            mismatch_count++;
        endfunction

        // compare one result word against the oldest prediction
        function void check_result(logic [7:0] word);
            res_t got;
            res_t want;
            got = res_t'(word);
            if (pending_pin_levels.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: result %0h arrived with nothing predicted", $realtime, word);
                mismatch_count++;
                return;
            end
            want = pending_pin_levels.pop_front();
            if (got.rs_pin !== want.rs_pin)
                report("rs_pin", {3'd0, want.rs_pin}, {3'd0, got.rs_pin});
            if (got.en_pin !== want.en_pin)
                report("en_pin", {3'd0, want.en_pin}, {3'd0, got.en_pin});
            if (got.data_pins !== want.data_pins)
                report("data_pins", want.data_pins, got.data_pins);
            if (got.busy_res !== want.busy_res)
                report("busy_res", {3'd0, want.busy_res}, {3'd0, got.busy_res});
            if (got.accepted !== want.accepted)
                report("accepted", {3'd0, want.accepted}, {3'd0, got.accepted});
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic [2:0]  s_tuser = ACT_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_PULSE;
    logic [9:0]  cfg_data = 10'd0;

    pin_level_checker checker_h;
    bit               pace_off = 1'b0;
    bit               burst = 1'b0;
    int               paced_items = 0;

    char_lcd_4bit_writer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // one input transaction; long waits are ticked through without gaps
    task automatic send_item(input logic [2:0] act, input logic [7:0] b, input logic row,
                             input logic [5:0] col);
        int gap;
        burst = pace_off || (checker_h.phase != PH_IDLE && checker_h.countdown > LONG_WAIT_US);
        gap = burst ? 0 : $urandom_range(9, 0);
        if (!burst)
            paced_items++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, col, row, b};
        do @(posedge aclk); while (!s_tready);
        checker_h.note_input(act, b, row, col);
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, 8'($urandom), 1'($urandom), 6'($urandom));
    endtask

    task automatic run_until_idle();
        while (checker_h.phase != PH_IDLE)
            send_tick();
    endtask

    // register write once the sequencer is idle and every result is back
    task automatic write_register(input logic [1:0] idx, input logic [9:0] value);
        run_until_idle();
        s_tvalid <= 1'b0;
        while (checker_h.pending_pin_levels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        checker_h.set_register(idx, value);
    endtask

    task automatic write_timing(input logic [9:0] pulse, input logic [9:0] hold,
                                input logic [9:0] gap);
        write_register(CFG_PULSE, pulse);
        write_register(CFG_HOLD, hold);
        write_register(CFG_GAP, gap);
    endtask

    // mostly complete requests ticked to idle, some cut short, some stray
    task automatic random_sequence();
        int         pick;
        int         n;
        logic [2:0] act;
        pick = $urandom_range(99, 0);
        pace_off = ($urandom_range(7, 0) == 0);
        if (pick < 12) begin
            act = 3'($urandom_range(7, 0));
            if (act == ACT_INIT)
                act = ACT_TICK;
            send_item(act, 8'($urandom), 1'($urandom), 6'($urandom));
        end else begin
            n = $urandom_range(39, 0);
            if (n == 0)
                act = ACT_CLEAR;
            else if (n < 14)
                act = ACT_CMD;
            else if (n < 27)
                act = ACT_DATA;
            else
                act = ACT_CURSOR;
            send_item(act, 8'($urandom), 1'($urandom), 6'($urandom));
            if (pick < 22) begin
                n = $urandom_range(4, 0);
                repeat (n) send_tick();
            end else begin
                while (checker_h.phase != PH_IDLE) begin
                    // requests here land on a busy block and must be refused
                    n = $urandom_range(15, 0);
                    if (n == 0)
                        act = 3'($urandom_range(ACT_CURSOR, ACT_CMD));
                    else if (n == 1)
                        act = 3'($urandom_range(7, 6));
                    else
                        act = ACT_TICK;
                    send_item(act, 8'($urandom), 1'($urandom), 6'($urandom));
                end
            end
        end
    endtask

    task automatic random_phase(input int target);
        paced_items = 0;
        while (paced_items < target)
            random_sequence();
        pace_off = 1'b0;
    endtask

    // result side with its own random stalls
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = burst ? 0 : $urandom_range(9, 0);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            checker_h.check_result(m_tdata);
        end
    end

    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        checker_h = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timing: an idle tick, unused codes, refused requests, every operation but init
        send_tick();
        send_item(3'd6, 8'hFF, 1'b1, 6'h3F);
        send_item(3'd7, 8'h00, 1'b0, 6'h00);
        send_item(ACT_CMD, 8'h00, 1'b0, 6'h00);
        send_item(ACT_DATA, 8'hFF, 1'b1, 6'h3F);
        send_item(ACT_INIT, 8'h00, 1'b0, 6'h00);
        send_item(ACT_CLEAR, 8'h00, 1'b0, 6'h00);
        send_item(ACT_CURSOR, 8'h00, 1'b1, 6'h3F);
        run_until_idle();
        send_item(ACT_DATA, 8'hFF, 1'b0, 6'h00);
        run_until_idle();
        send_item(ACT_CURSOR, 8'h00, 1'b1, 6'h3F);
        run_until_idle();
        send_item(ACT_CURSOR, 8'hFF, 1'b0, 6'h00);
        run_until_idle();
        send_item(ACT_CLEAR, 8'hFF, 1'b1, 6'h3F);
        run_until_idle();

        // zero timing: every pulse, hold and gap phase collapses into the request itself
        write_timing(10'd0, 10'd0, 10'd0);
        write_register(CFG_UNUSED, 10'h3FF);
        send_item(ACT_CMD, 8'hA5, 1'b0, 6'h00);
        send_item(ACT_DATA, 8'h5A, 1'b1, 6'h2A);
        send_item(ACT_CURSOR, 8'h00, 1'b1, 6'h15);
        send_item(ACT_CLEAR, 8'h00, 1'b0, 6'h00);
        run_until_idle();

        // power-on sequence with short pulses
        write_timing(10'd1, 10'd3, 10'd1);
        send_item(ACT_INIT, 8'h00, 1'b0, 6'h00);
        send_item(ACT_CMD, 8'h01, 1'b0, 6'h00);
        run_until_idle();

        // longest pulse, hold and gap; upper bits of the pulse write are dropped
        write_timing(10'h3FF, 10'd1023, 10'd1023);
        send_item(ACT_CMD, 8'h3C, 1'b0, 6'h00);
        run_until_idle();
        send_item(ACT_DATA, 8'hC3, 1'b0, 6'h00);
        run_until_idle();

        // random traffic under several short timings
        repeat (4) begin
            write_timing(10'($urandom_range(4, 0)), 10'($urandom_range(8, 0)),
                         10'($urandom_range(6, 0)));
            random_phase(300);
        end

        s_tvalid <= 1'b0;
        while (checker_h.pending_pin_levels.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (checker_h.mismatch_count == 0 && checker_h.pending_pin_levels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
